/* src/pkec_pkg.sv */
// Package for the power key event classifier: types, codes and reset values.
package pkec_pkg;

    // Stamp width; all time differences wrap modulo 2^TIME_W
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [TIME_W-1:0] stamp_t;
    typedef logic [MS_W-1:0]   ms_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2,
        PH_HOLD    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_HOLD  = 2'd3
    } event_t;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_MODE   = 3'd0,
        REG_LONG_PRESS    = 3'd1,
        REG_HOLD_REPEAT   = 3'd2,
        REG_SHORT_TIMEOUT = 3'd3,
        REG_LONG_TIMEOUT  = 3'd4
    } cfg_reg_t;

    // Flag-mode code for a short click alone
    localparam logic [1:0] FLAG_SHORT = 2'b10;
    localparam logic [1:0] FLAG_NONE  = 2'b00;

    localparam ms_t LONG_PRESS_RST    = 16'd1500;
    localparam ms_t HOLD_REPEAT_RST   = 16'd500;
    localparam ms_t SHORT_TIMEOUT_RST = 16'd2000;
    localparam ms_t LONG_TIMEOUT_RST  = 16'd10000;

    typedef struct packed {
        logic source_mode;
        ms_t  long_press_ms;
        ms_t  hold_repeat_ms;
        ms_t  short_timeout_ms;
        ms_t  long_timeout_ms;
    } cfg_t;

endpackage

/* src/pkec_cfg.sv */
// Configuration register file of the power key event classifier.
module pkec_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [pkec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pkec_pkg::MS_W-1:0]        cfg_data,
    output pkec_pkg::cfg_t                   cfg
);
    import pkec_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one register write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOURCE_MODE:   cfg_next.source_mode      = cfg_data[0];
                REG_LONG_PRESS:    cfg_next.long_press_ms    = cfg_data;
                REG_HOLD_REPEAT:   cfg_next.hold_repeat_ms   = cfg_data;
                REG_SHORT_TIMEOUT: cfg_next.short_timeout_ms = cfg_data;
                REG_LONG_TIMEOUT:  cfg_next.long_timeout_ms  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_mode      <= 1'b0;
            cfg_reg.long_press_ms    <= LONG_PRESS_RST;
            cfg_reg.hold_repeat_ms   <= HOLD_REPEAT_RST;
            cfg_reg.short_timeout_ms <= SHORT_TIMEOUT_RST;
            cfg_reg.long_timeout_ms  <= LONG_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/pkec_core.sv */
// Press state machine: one key word classified per enabled cycle.
module pkec_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  pkec_pkg::cfg_t         cfg,
    input  logic [31:0]            now_stamp,
    input  logic                   key_level,
    input  logic [1:0]             pek_flags,
    output pkec_pkg::event_t       event_code,
    output logic                   key_down,
    output logic [31:0]            held_ms
);
    import pkec_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    logic   down_reg;
    logic   down_next;
    stamp_t press_reg;
    stamp_t press_next;
    stamp_t last_reg;
    stamp_t last_next;

    stamp_t now;
    stamp_t dur;
    stamp_t since;
    event_t ev;

    assign now   = TIME_W'(now_stamp);
    // dur sees this word's press stamp; since the stored event stamp
    assign dur   = now - press_next;
    assign since = now - last_reg;

    // Next state and event for the current word
    always_comb
    begin
        phase_next = phase_reg;
        down_next  = down_reg;
        press_next = press_reg;
        last_next  = last_reg;
        ev         = EV_NONE;

        if (!cfg.source_mode)
        begin
            // Level mode: rising edge starts a press
            down_next = key_level;
            if (key_level && !down_reg)
            begin
                press_next = now;
                phase_next = PH_PRESSED;
            end
            if (key_level)
            begin
                if (phase_next == PH_PRESSED)
                begin
                    if (dur >= TIME_W'(cfg.long_press_ms))
                    begin
                        phase_next = PH_LONG;
                        last_next  = now;
                        ev         = EV_LONG;
                    end
                end
                else if (since >= TIME_W'(cfg.hold_repeat_ms))
                begin
                    // idle-while-down counts as past long press
                    phase_next = PH_HOLD;
                    last_next  = now;
                    ev         = EV_HOLD;
                end
            end
            else
            begin
                if (phase_next == PH_PRESSED)
                    ev = EV_SHORT;
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            // Flag mode: any flag restarts the press
            if (pek_flags != FLAG_NONE)
            begin
                down_next  = 1'b1;
                press_next = now;
                if (pek_flags == FLAG_SHORT)
                    phase_next = PH_PRESSED;
                else
                begin
                    phase_next = PH_LONG;
                    last_next  = now;
                    ev         = EV_LONG;
                end
            end
            if (ev == EV_NONE && down_next)
            begin
                if (phase_next == PH_PRESSED)
                begin
                    if (dur >= TIME_W'(cfg.long_press_ms))
                    begin
                        phase_next = PH_LONG;
                        last_next  = now;
                        ev         = EV_LONG;
                    end
                    else if (dur >= TIME_W'(cfg.short_timeout_ms))
                    begin
                        down_next  = 1'b0;
                        phase_next = PH_IDLE;
                        ev         = EV_SHORT;
                    end
                end
                else
                begin
                    if (since >= TIME_W'(cfg.hold_repeat_ms))
                    begin
                        phase_next = PH_HOLD;
                        last_next  = now;
                        ev         = EV_HOLD;
                    end
                    else if (dur >= TIME_W'(cfg.long_timeout_ms))
                    begin
                        // missed release: drop the key silently
                        down_next  = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            down_reg  <= 1'b0;
            press_reg <= '0;
            last_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            down_reg  <= down_next;
            press_reg <= press_next;
            last_reg  <= last_next;
        end
    end

    assign event_code = ev;
    assign key_down   = down_next;
    assign held_ms    = down_next ? 32'(dur) : 32'd0;

    // A short press always leaves the key up
    a_short_releases: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && ev == EV_SHORT |=> !down_reg)
        else $error("short press left key down");

    // Long and hold events restamp the event time and keep the key down
    a_event_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (ev == EV_LONG || ev == EV_HOLD)
        |=> down_reg && last_reg == $past(now))
        else $error("event stamp not updated");

    // Nothing moves in the state unless a word is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(down_reg) && $stable(press_reg))
        else $error("state changed without a word");

endmodule

/* src/power_key_event_classifier_unit.sv */
// Top level of the power key event classifier: input and result registers.
//
// Takes one key word per clock unless stalled; one result word per key word, in order.
// A word passes through the input register and then the result register; the
// press state is updated from its own registers with no extra register in its loop, so a new
// word may be accepted every cycle while the result register is drained. The
// configuration port accepts a write every cycle and should only be used while no
// words are in flight.
module power_key_event_classifier_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pkec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pkec_pkg::MS_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [31:0]                      now_stamp,
    input  logic                             key_level,
    input  logic [1:0]                       pek_flags,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       event_code,
    output logic                             key_down,
    output logic [31:0]                      held_ms
);
    import pkec_pkg::*;

    cfg_t   cfg;

    logic        s1_valid_reg;
    logic [31:0] s1_now_reg;
    logic        s1_level_reg;
    logic [1:0]  s1_flags_reg;

    logic        out_valid_reg;
    event_t      out_event_reg;
    logic        out_down_reg;
    logic [31:0] out_held_reg;

    logic        s1_advance;
    logic        step_en;
    event_t      core_event;
    logic        core_down;
    logic [31:0] core_held;

    assign cfg_ready = 1'b1;

    pkec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the input register moves on when the result register is empty or being read
    assign s1_advance = !out_valid_reg || out_ready;
    assign step_en    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_now_reg   <= now_stamp;
            s1_level_reg <= key_level;
            s1_flags_reg <= pek_flags;
        end
    end

    pkec_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .cfg        (cfg),
        .now_stamp  (s1_now_reg),
        .key_level  (s1_level_reg),
        .pek_flags  (s1_flags_reg),
        .event_code (core_event),
        .key_down   (core_down),
        .held_ms    (core_held)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_event_reg <= core_event;
            out_down_reg  <= core_down;
            out_held_reg  <= core_held;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_event_reg;
    assign key_down   = out_down_reg;
    assign held_ms    = out_held_reg;

    // A released key reports no held time
    a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_down_reg |-> out_held_reg == 32'd0)
        else $error("held time nonzero with key up");

    // An empty input register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled while empty");

    // A processed word always lands in the result register
    a_word_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("processed word lost");

endmodule

/* sim/power_key_event_classifier_unit_test.sv */
// Self-checking testbench for the power key event classifier unit.
module power_key_event_classifier_unit_test;
    import pkec_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 21;
    localparam int REPORT_MAX   = 10;
    localparam int QUIET_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 120;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [1:0] FLAG_LONG = 2'b01;
    localparam logic [1:0] FLAG_BOTH = 2'b11;

    typedef struct packed {
        event_t ev;
        logic   down;
        stamp_t held;
    } key_result_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        ms_t                  reg_val;
        stamp_t               stamp;
        logic                 level;
        logic [1:0]           flags;
        bit                   typed;
        key_result_t          want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MS_W-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          now_stamp;
    logic                 key_level;
    logic [1:0]           pek_flags;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           event_code;
    logic                 key_down;
    logic [31:0]          held_ms;

    // Predictor copy of configuration and press state
    logic   cfg_mode;
    ms_t    cfg_long;
    ms_t    cfg_repeat;
    ms_t    cfg_short_to;
    ms_t    cfg_long_to;
    phase_t trk_phase;
    logic   trk_down;
    stamp_t trk_press_at;
    stamp_t trk_last_evt;

    key_result_t owed_results[$];
    plan_row_t   plan[$];
    int          mismatches  = 0;
    int          word_count  = 0;
    int          cycle_count = 0;
    bit          steady      = 1'b0;

    power_key_event_classifier_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .now_stamp  (now_stamp),
        .key_level  (key_level),
        .pek_flags  (pek_flags),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .key_down   (key_down),
        .held_ms    (held_ms)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One step of the press state machine; updates the predictor state
    function automatic key_result_t classify_key(stamp_t now, logic level, logic [1:0] flags);
        key_result_t r;
        logic        was;
        stamp_t      dur;
        stamp_t      since;
        r.ev = EV_NONE;
        if (cfg_mode == 1'b0)
        begin
            was = trk_down;
            trk_down = level;
            if (level && !was)
            begin
                trk_press_at = now;
                trk_phase = PH_PRESSED;
            end
            dur = now - trk_press_at;
            since = now - trk_last_evt;
            if (trk_down)
            begin
                if (trk_phase == PH_PRESSED)
                begin
                    if (dur >= cfg_long)
                    begin
                        trk_phase = PH_LONG;
                        trk_last_evt = now;
                        r.ev = EV_LONG;
                    end
                end
                else if (since >= cfg_repeat)
                begin
                    trk_phase = PH_HOLD;
                    trk_last_evt = now;
                    r.ev = EV_HOLD;
                end
            end
            else
            begin
                if (trk_phase == PH_PRESSED)
                    r.ev = EV_SHORT;
                trk_phase = PH_IDLE;
            end
        end
        else
        begin
            // Any flag restarts the press; long or both fire at once
            if (flags != FLAG_NONE)
            begin
                trk_down = 1'b1;
                trk_press_at = now;
                if (flags == FLAG_SHORT)
                    trk_phase = PH_PRESSED;
                else
                begin
                    trk_phase = PH_LONG;
                    trk_last_evt = now;
                    r.ev = EV_LONG;
                end
            end
            dur = now - trk_press_at;
            since = now - trk_last_evt;
            if (r.ev == EV_NONE && trk_down)
            begin
                if (trk_phase == PH_PRESSED)
                begin
                    if (dur >= cfg_long)
                    begin
                        trk_phase = PH_LONG;
                        trk_last_evt = now;
                        r.ev = EV_LONG;
                    end
                    else if (dur >= cfg_short_to)
                    begin
                        trk_down = 1'b0;
                        trk_phase = PH_IDLE;
                        r.ev = EV_SHORT;
                    end
                end
                else if (since >= cfg_repeat)
                begin
                    trk_phase = PH_HOLD;
                    trk_last_evt = now;
                    r.ev = EV_HOLD;
                end
                else if (dur >= cfg_long_to)
                begin
                    // missed release: drop the key with no event
                    trk_down = 1'b0;
                    trk_phase = PH_IDLE;
                end
            end
        end
        r.down = trk_down;
        r.held = trk_down ? now - trk_press_at : '0;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, ms_t val);
        case (idx)
            REG_SOURCE_MODE:   cfg_mode = val[0];
            REG_LONG_PRESS:    cfg_long = val;
            REG_HOLD_REPEAT:   cfg_repeat = val;
            REG_SHORT_TIMEOUT: cfg_short_to = val;
            REG_LONG_TIMEOUT:  cfg_long_to = val;
            default: ;
        endcase
    endfunction

    // Stimulus plan builders
    task automatic plan_cfg(logic [CFG_IDX_W-1:0] idx, ms_t val);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endtask

    task automatic plan_word(stamp_t stamp, logic level, logic [1:0] flags);
        plan_row_t row;
        row = '{default: '0};
        row.stamp = stamp;
        row.level = level;
        row.flags = flags;
        plan.push_back(row);
    endtask

    task automatic plan_known(stamp_t stamp, logic level, logic [1:0] flags,
                              event_t ev, logic down, stamp_t held);
        plan_row_t row;
        row = '{default: '0};
        row.stamp = stamp;
        row.level = level;
        row.flags = flags;
        row.typed = 1'b1;
        row.want.ev = ev;
        row.want.down = down;
        row.want.held = held;
        plan.push_back(row);
    endtask

    // Register write; the block must be idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, ms_t val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one key word with random gaps ahead of it
    task automatic send_word(stamp_t stamp, logic level, logic [1:0] flags,
                             bit typed, key_result_t want);
        key_result_t got;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        now_stamp = stamp;
        key_level = level;
        pek_flags = flags;
        do @(posedge clk); while (!in_ready);
        got = classify_key(stamp, level, flags);
        owed_results.push_back(typed ? want : got);
        word_count++;
    endtask

    // Stop sending and wait until every result is back
    task automatic wait_quiet();
        @(negedge clk);
        in_valid = 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic ms_t pick_ms();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return ms_t'($urandom_range(0, 65535));
            default: return ms_t'($urandom_range(1, 2500));
        endcase
    endfunction

    // Result receiver stalls
    always @(negedge clk)
        out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Result checker
    always @(posedge clk)
    begin : check_results
        key_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word: ev=%0d down=%0d held=%0d",
                             event_code, key_down, held_ms);
            end
            else
            begin
                want = owed_results.pop_front();
                if (event_code !== want.ev || key_down !== want.down || held_ms !== want.held)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"result mismatch: want ev=%0d down=%0d held=%0d, ",
                                  "got ev=%0d down=%0d held=%0d"},
                                 want.ev, want.down, want.held,
                                 event_code, key_down, held_ms);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("power_key_event_classifier_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        stamp_t      clock_ms;
        logic        key_now;
        bit          start_press;
        int          run_left;
        logic        level;
        logic [1:0]  flags;
        int          r;
        key_result_t none_owed;

        none_owed = '0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        now_stamp = '0;
        key_level = 1'b0;
        pek_flags = FLAG_NONE;
        cfg_mode = 1'b0;
        cfg_long = LONG_PRESS_RST;
        cfg_repeat = HOLD_REPEAT_RST;
        cfg_short_to = SHORT_TIMEOUT_RST;
        cfg_long_to = LONG_TIMEOUT_RST;
        trk_phase = PH_IDLE;
        trk_down = 1'b0;
        trk_press_at = '0;
        trk_last_evt = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Level mode with reset settings
        plan_known(32'd0,    1'b0, FLAG_NONE, EV_NONE, 1'b0, 32'd0);
        plan_known(32'd100,  1'b1, FLAG_NONE, EV_NONE, 1'b1, 32'd0);
        plan_known(32'd1600, 1'b1, FLAG_NONE, EV_LONG, 1'b1, 32'd1500);
        plan_known(32'd2100, 1'b1, FLAG_NONE, EV_HOLD, 1'b1, 32'd2000);
        plan_known(32'd2300, 1'b0, FLAG_NONE, EV_NONE, 1'b0, 32'd0);
        plan_word(32'd3000, 1'b1, FLAG_NONE);
        plan_known(32'd3100, 1'b0, FLAG_NONE, EV_SHORT, 1'b0, 32'd0);
        // press straddling the stamp wrap; flags are ignored here
        plan_word(32'hFFFF_FF00, 1'b1, FLAG_BOTH);
        plan_word(32'h0000_04E0, 1'b1, FLAG_BOTH);
        plan_word(32'hFFFF_FFFF, 1'b0, FLAG_SHORT);
        // Flag mode, reset thresholds
        plan_cfg(REG_SOURCE_MODE, 16'd1);
        plan_word(32'd5000,  1'b1, FLAG_SHORT);
        plan_word(32'd7000,  1'b0, FLAG_NONE);
        plan_word(32'd17000, 1'b1, FLAG_NONE);
        plan_known(32'd20000, 1'b0, FLAG_LONG, EV_LONG, 1'b1, 32'd0);
        plan_known(32'd20001, 1'b1, FLAG_BOTH, EV_LONG, 1'b1, 32'd0);
        // short and long safety timeouts
        plan_cfg(REG_LONG_PRESS, 16'hFFFF);
        plan_cfg(REG_HOLD_REPEAT, 16'hFFFF);
        plan_word(32'd30000, 1'b0, FLAG_SHORT);
        plan_known(32'd32000, 1'b0, FLAG_NONE, EV_SHORT, 1'b0, 32'd0);
        plan_known(32'd40000, 1'b0, FLAG_LONG, EV_LONG, 1'b1, 32'd0);
        plan_known(32'd50000, 1'b0, FLAG_NONE, EV_NONE, 1'b0, 32'd0);
        // zero thresholds, plus a write to a spare index
        plan_cfg(REG_SPARE_FIRST, 16'hFFFF);
        plan_cfg(REG_LONG_PRESS, 16'd0);
        plan_cfg(REG_HOLD_REPEAT, 16'd0);
        plan_cfg(REG_SHORT_TIMEOUT, 16'd0);
        plan_cfg(REG_LONG_TIMEOUT, 16'd0);
        plan_known(32'd60000, 1'b0, FLAG_SHORT, EV_LONG, 1'b1, 32'd0);
        plan_known(32'd60000, 1'b0, FLAG_NONE, EV_HOLD, 1'b1, 32'd0);
        // back to level mode in the middle of a held press
        plan_cfg(REG_SOURCE_MODE, 16'd0);
        plan_word(32'd60010, 1'b1, FLAG_NONE);
        plan_word(32'd60020, 1'b0, FLAG_NONE);
        plan_word(32'd70000, 1'b1, FLAG_LONG);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_quiet();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_word(plan[i].stamp, plan[i].level, plan[i].flags,
                          plan[i].typed, plan[i].want);
        end

        // Random phases: press sequences with random timing, some noise
        clock_ms = $urandom;
        key_now = 1'b0;
        run_left = 0;
        start_press = 1'b0;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_quiet();
            write_reg(REG_SOURCE_MODE, (ph < 4) ? ms_t'(ph % 2) : ms_t'($urandom_range(0, 1)));
            write_reg(REG_LONG_PRESS, pick_ms());
            write_reg(REG_HOLD_REPEAT, pick_ms());
            write_reg(REG_SHORT_TIMEOUT, pick_ms());
            write_reg(REG_LONG_TIMEOUT, pick_ms());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SPARE_LAST, ms_t'($urandom));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // hold off once until the pipe is empty
                if (ph == 3 && n == PHASE_WORDS / 2)
                    wait_quiet();
                steady = (word_count >= 400 && word_count < 560);

                case ($urandom_range(0, 19))
                    0: clock_ms = $urandom;
                    1: ;
                    default: clock_ms = clock_ms + $urandom_range(1, 600);
                endcase

                if (run_left == 0)
                begin
                    key_now = !key_now;
                    run_left = key_now ? $urandom_range(1, 25) : $urandom_range(1, 4);
                    start_press = key_now;
                end
                run_left--;

                level = key_now;
                if ($urandom_range(0, 19) == 0)
                    level = !level;
                flags = FLAG_NONE;
                if (start_press)
                begin
                    r = $urandom_range(0, 9);
                    flags = (r < 6) ? FLAG_SHORT : (r < 8) ? FLAG_LONG : FLAG_BOTH;
                end
                if ($urandom_range(0, 24) == 0)
                    flags = 2'($urandom_range(0, 3));
                start_press = 1'b0;

                // the field the current mode ignores gets random values
                if (cfg_mode == 1'b0)
                    flags = 2'($urandom_range(0, 3));
                else
                    level = 1'($urandom_range(0, 1));

                send_word(clock_ms, level, flags, 1'b0, none_owed);
            end
        end
        steady = 1'b0;

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("power_key_event_classifier_unit_test: clean");
        else
            $display("power_key_event_classifier_unit_test: errors");
        $finish;
    end

endmodule

/* sim.f */
src/pkec_pkg.sv
src/pkec_cfg.sv
src/pkec_core.sv
src/power_key_event_classifier_unit.sv
sim/power_key_event_classifier_unit_test.sv
